// ===== rtl/core/nifd_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// nifd_pkg
// Shared types, constants and helpers of the NEC infrared frame decoder.
// ============================================================================
package nifd_pkg;

    localparam int unsigned VAL_W         = 15;
    localparam int unsigned CMD_W         = 8;
    localparam int unsigned RELAY_W       = 4;
    localparam int unsigned KIND_W        = 2;
    localparam int unsigned CFG_IDX_W     = 3;

    localparam int unsigned FRAME_INTERVALS = 34;

    // first interval of the command byte and of the inverted command byte
    localparam int unsigned CMD_FIRST = 18;
    localparam int unsigned INV_FIRST = 26;
    localparam int unsigned BYTE_BITS = 8;

    // reset values of the timing windows, microseconds
    localparam logic [VAL_W-1:0] LEADER_MIN_RST = 15'd4500;
    localparam logic [VAL_W-1:0] LEADER_MAX_RST = 15'd5500;
    localparam logic [VAL_W-1:0] ZERO_MIN_RST   = 15'd900;
    localparam logic [VAL_W-1:0] ZERO_MAX_RST   = 15'd1500;
    localparam logic [VAL_W-1:0] ONE_MIN_RST    = 15'd1800;
    localparam logic [VAL_W-1:0] ONE_MAX_RST    = 15'd2500;
    localparam logic [VAL_W-1:0] REPEAT_MIN_RST = 15'd2500;
    localparam logic [VAL_W-1:0] REPEAT_MAX_RST = 15'd3000;

    localparam logic [RELAY_W-1:0] RELAY_RST   = 4'hF;
    localparam logic [RELAY_W-1:0] RELAY_NONE  = 4'h0;
    localparam logic [RELAY_W-1:0] RELAY_ALL   = 4'hF;

    // remote button codes acting on the relays
    localparam logic [CMD_W-1:0] CMD_TOGGLE0 = 8'd12;
    localparam logic [CMD_W-1:0] CMD_TOGGLE1 = 8'd24;
    localparam logic [CMD_W-1:0] CMD_TOGGLE2 = 8'd94;
    localparam logic [CMD_W-1:0] CMD_TOGGLE3 = 8'd8;
    localparam logic [CMD_W-1:0] CMD_ALL_OFF = 8'd70;
    localparam logic [CMD_W-1:0] CMD_ALL_ON  = 8'd69;

    typedef enum logic [KIND_W-1:0] {
        EV_VALID      = 2'd0,
        EV_REPEAT     = 2'd1,
        EV_BIT_ERROR  = 2'd2,
        EV_BAD_LEADER = 2'd3
    } event_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEADER_MIN = 3'd0,
        CFG_LEADER_MAX = 3'd1,
        CFG_ZERO_MIN   = 3'd2,
        CFG_ZERO_MAX   = 3'd3,
        CFG_ONE_MIN    = 3'd4,
        CFG_ONE_MAX    = 3'd5,
        CFG_REPEAT_MIN = 3'd6,
        CFG_REPEAT_MAX = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [VAL_W-1:0] leader_min;
        logic [VAL_W-1:0] leader_max;
        logic [VAL_W-1:0] zero_min;
        logic [VAL_W-1:0] zero_max;
        logic [VAL_W-1:0] one_min;
        logic [VAL_W-1:0] one_max;
        logic [VAL_W-1:0] repeat_min;
        logic [VAL_W-1:0] repeat_max;
    } cfg_t;

    // window hits of one interval
    typedef struct packed {
        logic in_leader;
        logic in_repeat;
        logic is_zero;
        logic is_one;
    } class_t;

    typedef struct packed {
        logic                valid;
        event_kind_t         kind;
        logic [CMD_W-1:0]    command;
        logic [RELAY_W-1:0]  relay;
    } result_t;

    function automatic logic in_window(input logic [VAL_W-1:0] v,
                                       input logic [VAL_W-1:0] lo,
                                       input logic [VAL_W-1:0] hi);
        return (lo <= v) && (v <= hi);
    endfunction

endpackage

// ===== rtl/core/nec_ir_frame_decoder_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// nec_ir_frame_decoder_top
// NEC-style infrared frame decoder driving four relay bits.
// ============================================================================
// Each request on the s_ stream is one time between rising edges of the IR
// receiver, in microseconds. The decoder counts the intervals of a frame:
// interval 1 is a leader or a repeat gap (a repeat gap ends the frame at once
// and reports a held key), intervals 18 to 25 carry the command and 26 to 33
// its inverse, LSB first, and the last interval closes the frame with one
// event on the m_ stream. All other intervals produce no event. A good
// command whose two copies agree toggles, clears or sets the relay bits. The
// block takes one request per clock unless stalled: a request is held in an
// input register, decoded by window compares and the frame logic, and its
// event lands in an output register that drives m_tvalid. Throughput is one
// request per cycle while s_tready is high; s_tready drops only while an
// event waits in the output register with m_tready low. Write the timing
// windows through cfg_* only while no request is in flight; windows are
// inclusive and a window with min above max is empty.
// ============================================================================
module nec_ir_frame_decoder_top #(
    parameter int unsigned FRAME_INTERVALS = nifd_pkg::FRAME_INTERVALS
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // interval requests
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [14:0] interval_us

    // events
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // [7:0] command, [11:8] relay_bits
    output logic [nifd_pkg::KIND_W-1:0]     m_tuser,   // [1:0] event_kind

    // window register writes
    input  logic                            cfg_wen,
    input  logic [nifd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nifd_pkg::VAL_W-1:0]      cfg_wdata
);

    nifd_pkg::cfg_t    cfg;
    nifd_pkg::class_t  cls;
    nifd_pkg::result_t res;

    logic                       in_valid_reg;
    logic [nifd_pkg::VAL_W-1:0] in_data_reg;
    logic                       advance;

    logic                         out_valid_reg;
    nifd_pkg::event_kind_t        out_kind_reg;
    logic [nifd_pkg::CMD_W-1:0]   out_cmd_reg;
    logic [nifd_pkg::RELAY_W-1:0] out_relay_reg;

    // advance the held request whenever the output register is free or
    // being emptied this cycle
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // payload: no reset needed
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata[nifd_pkg::VAL_W-1:0];
        end
    end

    nifd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    nifd_classify u_classify (
        .interval_us (in_data_reg),
        .cfg         (cfg),
        .cls         (cls)
    );

    nifd_frame #(
        .FRAME_INTERVALS (FRAME_INTERVALS)
    ) u_frame (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .cls     (cls),
        .res     (res)
    );

    // output register: load a new event, drop the old one once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            out_kind_reg  <= res.kind;
            out_cmd_reg   <= res.command;
            out_relay_reg <= res.relay;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {4'b0000, out_relay_reg, out_cmd_reg};

endmodule

// ===== rtl/core/nifd_cfg_regs.sv =====
`timescale 1ns / 1ps
// ============================================================================
// nifd_cfg_regs
// Timing window registers, written through the plain write port.
// ============================================================================
module nifd_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wen,
    input  logic [nifd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nifd_pkg::VAL_W-1:0]      cfg_wdata,
    output nifd_pkg::cfg_t                  cfg
);

    nifd_pkg::cfg_t cfg_reg;
    nifd_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wen) begin
            case (nifd_pkg::cfg_index_t'(cfg_index))
                nifd_pkg::CFG_LEADER_MIN: cfg_next.leader_min = cfg_wdata;
                nifd_pkg::CFG_LEADER_MAX: cfg_next.leader_max = cfg_wdata;
                nifd_pkg::CFG_ZERO_MIN:   cfg_next.zero_min   = cfg_wdata;
                nifd_pkg::CFG_ZERO_MAX:   cfg_next.zero_max   = cfg_wdata;
                nifd_pkg::CFG_ONE_MIN:    cfg_next.one_min    = cfg_wdata;
                nifd_pkg::CFG_ONE_MAX:    cfg_next.one_max    = cfg_wdata;
                nifd_pkg::CFG_REPEAT_MIN: cfg_next.repeat_min = cfg_wdata;
                nifd_pkg::CFG_REPEAT_MAX: cfg_next.repeat_max = cfg_wdata;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.leader_min <= nifd_pkg::LEADER_MIN_RST;
            cfg_reg.leader_max <= nifd_pkg::LEADER_MAX_RST;
            cfg_reg.zero_min   <= nifd_pkg::ZERO_MIN_RST;
            cfg_reg.zero_max   <= nifd_pkg::ZERO_MAX_RST;
            cfg_reg.one_min    <= nifd_pkg::ONE_MIN_RST;
            cfg_reg.one_max    <= nifd_pkg::ONE_MAX_RST;
            cfg_reg.repeat_min <= nifd_pkg::REPEAT_MIN_RST;
            cfg_reg.repeat_max <= nifd_pkg::REPEAT_MAX_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/nifd_classify.sv =====
`timescale 1ns / 1ps
// ============================================================================
// nifd_classify
// Window compares of one interval against the four timing windows.
// ============================================================================
module nifd_classify (
    input  logic [nifd_pkg::VAL_W-1:0] interval_us,
    input  nifd_pkg::cfg_t             cfg,
    output nifd_pkg::class_t           cls
);

    logic hit_zero;
    logic hit_one;

    assign hit_zero = nifd_pkg::in_window(interval_us, cfg.zero_min, cfg.zero_max);
    assign hit_one  = nifd_pkg::in_window(interval_us, cfg.one_min, cfg.one_max);

    always_comb begin
        cls.in_leader = nifd_pkg::in_window(interval_us, cfg.leader_min, cfg.leader_max);
        cls.in_repeat = nifd_pkg::in_window(interval_us, cfg.repeat_min, cfg.repeat_max);
        // zero window wins where the bit windows overlap
        cls.is_zero   = hit_zero;
        cls.is_one    = !hit_zero && hit_one;
    end

endmodule

// ===== rtl/core/nifd_frame.sv =====
`timescale 1ns / 1ps
// ============================================================================
// nifd_frame
// Frame position, command shift registers, last command and relay state.
// Produces the event of the interval being stepped in the same cycle.
// ============================================================================
module nifd_frame #(
    parameter int unsigned FRAME_INTERVALS = nifd_pkg::FRAME_INTERVALS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  nifd_pkg::class_t    cls,
    output nifd_pkg::result_t   res
);

    localparam int unsigned IDX_W = $clog2(FRAME_INTERVALS);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(FRAME_INTERVALS - 1);
    localparam logic [IDX_W-1:0] IDX_LEAD  = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_CMD0  = IDX_W'(nifd_pkg::CMD_FIRST);
    localparam logic [IDX_W-1:0] IDX_CMD1  =
        IDX_W'(nifd_pkg::CMD_FIRST + nifd_pkg::BYTE_BITS);
    localparam logic [IDX_W-1:0] IDX_INV0  = IDX_W'(nifd_pkg::INV_FIRST);
    localparam logic [IDX_W-1:0] IDX_INV1  =
        IDX_W'(nifd_pkg::INV_FIRST + nifd_pkg::BYTE_BITS);

    logic [IDX_W-1:0]             idx_reg,     idx_next;
    logic                         leader_reg,  leader_next;
    logic [nifd_pkg::CMD_W-1:0]   cmd_sh_reg,  cmd_sh_next;
    logic [nifd_pkg::CMD_W-1:0]   inv_sh_reg,  inv_sh_next;
    logic                         cmd_bad_reg, cmd_bad_next;
    logic                         inv_bad_reg, inv_bad_next;
    logic [nifd_pkg::CMD_W-1:0]   last_reg,    last_next;
    logic [nifd_pkg::RELAY_W-1:0] relay_reg,   relay_next;

    logic [nifd_pkg::CMD_W-1:0]   cmd_sh_upd, inv_sh_upd;
    logic                         cmd_bad_upd, inv_bad_upd, leader_upd;
    logic                         in_cmd, in_inv, bit_bad;

    function automatic logic [nifd_pkg::RELAY_W-1:0] relay_apply(
        input logic [nifd_pkg::CMD_W-1:0]   c,
        input logic [nifd_pkg::RELAY_W-1:0] r);
        logic [nifd_pkg::RELAY_W-1:0] o;
        o = r;
        case (c)
            nifd_pkg::CMD_TOGGLE0: o = r ^ 4'b0001;
            nifd_pkg::CMD_TOGGLE1: o = r ^ 4'b0010;
            nifd_pkg::CMD_TOGGLE2: o = r ^ 4'b0100;
            nifd_pkg::CMD_TOGGLE3: o = r ^ 4'b1000;
            nifd_pkg::CMD_ALL_OFF: o = nifd_pkg::RELAY_NONE;
            nifd_pkg::CMD_ALL_ON:  o = nifd_pkg::RELAY_ALL;
            default:               o = r;
        endcase
        return o;
    endfunction

    assign in_cmd  = (idx_reg >= IDX_CMD0) && (idx_reg < IDX_CMD1);
    assign in_inv  = (idx_reg >= IDX_INV0) && (idx_reg < IDX_INV1);
    assign bit_bad = !cls.is_zero && !cls.is_one;

    // shift this interval into the frame state
    always_comb begin
        leader_upd  = leader_reg;
        cmd_sh_upd  = cmd_sh_reg;
        inv_sh_upd  = inv_sh_reg;
        cmd_bad_upd = cmd_bad_reg;
        inv_bad_upd = inv_bad_reg;
        if (idx_reg == IDX_LEAD) begin
            leader_upd = cls.in_leader;
        end
        if (in_cmd) begin
            cmd_bad_upd = cmd_bad_reg || bit_bad;
            cmd_sh_upd  = {cls.is_one, cmd_sh_reg[nifd_pkg::CMD_W-1:1]};
        end
        if (in_inv) begin
            // store the inverse byte already inverted
            inv_bad_upd = inv_bad_reg || bit_bad;
            inv_sh_upd  = {cls.is_zero, inv_sh_reg[nifd_pkg::CMD_W-1:1]};
        end
    end

    always_comb begin
        idx_next     = idx_reg;
        leader_next  = leader_reg;
        cmd_sh_next  = cmd_sh_reg;
        inv_sh_next  = inv_sh_reg;
        cmd_bad_next = cmd_bad_reg;
        inv_bad_next = inv_bad_reg;
        last_next    = last_reg;
        relay_next   = relay_reg;
        res.valid    = 1'b0;
        res.kind     = nifd_pkg::EV_VALID;

        if (step) begin
            if ((idx_reg == IDX_LEAD) && cls.in_repeat) begin
                res.valid = 1'b1;
                res.kind  = nifd_pkg::EV_REPEAT;
                idx_next  = '0;
                leader_next  = 1'b0;
                cmd_sh_next  = '0;
                inv_sh_next  = '0;
                cmd_bad_next = 1'b0;
                inv_bad_next = 1'b0;
            end else if (idx_reg != IDX_LAST) begin
                idx_next     = idx_reg + IDX_W'(1);
                leader_next  = leader_upd;
                cmd_sh_next  = cmd_sh_upd;
                inv_sh_next  = inv_sh_upd;
                cmd_bad_next = cmd_bad_upd;
                inv_bad_next = inv_bad_upd;
            end else begin
                res.valid = 1'b1;
                if (!leader_upd) begin
                    res.kind = nifd_pkg::EV_BAD_LEADER;
                end else begin
                    last_next = cmd_bad_upd ? '0 : cmd_sh_upd;
                    if (!cmd_bad_upd && !inv_bad_upd && (cmd_sh_upd == inv_sh_upd)) begin
                        res.kind   = nifd_pkg::EV_VALID;
                        relay_next = relay_apply(cmd_sh_upd, relay_reg);
                    end else begin
                        res.kind = nifd_pkg::EV_BIT_ERROR;
                    end
                end
                idx_next     = '0;
                leader_next  = 1'b0;
                cmd_sh_next  = '0;
                inv_sh_next  = '0;
                cmd_bad_next = 1'b0;
                inv_bad_next = 1'b0;
            end
        end
        res.command = last_next;
        res.relay   = relay_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            leader_reg  <= 1'b0;
            cmd_sh_reg  <= '0;
            inv_sh_reg  <= '0;
            cmd_bad_reg <= 1'b0;
            inv_bad_reg <= 1'b0;
            last_reg    <= '0;
            relay_reg   <= nifd_pkg::RELAY_RST;
        end else begin
            idx_reg     <= idx_next;
            leader_reg  <= leader_next;
            cmd_sh_reg  <= cmd_sh_next;
            inv_sh_reg  <= inv_sh_next;
            cmd_bad_reg <= cmd_bad_next;
            inv_bad_reg <= inv_bad_next;
            last_reg    <= last_next;
            relay_reg   <= relay_next;
        end
    end

endmodule

// ===== rtl/core/nifd_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// nifd_checker
// Port-level checks of the decoder, bound to the top level.
// ============================================================================
module nifd_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [15:0]                     m_tdata,
    input  logic [nifd_pkg::KIND_W-1:0]     m_tuser
);

    logic [nifd_pkg::CMD_W-1:0]   prev_cmd_reg;
    logic [nifd_pkg::RELAY_W-1:0] prev_relay_reg;
    logic [nifd_pkg::CMD_W-1:0]   cur_cmd;
    logic [nifd_pkg::RELAY_W-1:0] cur_relay;
    logic                         relay_code;

    assign cur_cmd   = m_tdata[7:0];
    assign cur_relay = m_tdata[11:8];
    assign relay_code = (cur_cmd == nifd_pkg::CMD_TOGGLE0) ||
                        (cur_cmd == nifd_pkg::CMD_TOGGLE1) ||
                        (cur_cmd == nifd_pkg::CMD_TOGGLE2) ||
                        (cur_cmd == nifd_pkg::CMD_TOGGLE3) ||
                        (cur_cmd == nifd_pkg::CMD_ALL_OFF) ||
                        (cur_cmd == nifd_pkg::CMD_ALL_ON);

    // track the last delivered command and relay bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_cmd_reg   <= '0;
            prev_relay_reg <= nifd_pkg::RELAY_RST;
        end else if (m_tvalid && m_tready) begin
            prev_cmd_reg   <= cur_cmd;
            prev_relay_reg <= cur_relay;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("event changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("event shown right after reset");

    a_relay_only_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != nifd_pkg::EV_VALID) |-> cur_relay == prev_relay_reg)
        else $error("relay bits moved on a non-command event");

    a_cmd_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tuser == nifd_pkg::EV_REPEAT) || (m_tuser == nifd_pkg::EV_BAD_LEADER))
        |-> cur_cmd == prev_cmd_reg)
        else $error("last command changed on repeat or bad leader");

    a_unknown_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == nifd_pkg::EV_VALID) && !relay_code
        |-> cur_relay == prev_relay_reg)
        else $error("relay bits moved on a code with no relay action");

endmodule

bind nec_ir_frame_decoder_top nifd_checker u_nifd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
